// File: rtl/digital_input_toggle_channels_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the digital input toggle channels block
// Shared helpers for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef DIGITAL_INPUT_TOGGLE_CHANNELS_TOP_MACROS_SVH
`define DIGITAL_INPUT_TOGGLE_CHANNELS_TOP_MACROS_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define DITC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after a reset cycle.
`define DITC_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/ditc_pkg.sv
// ----------------------------------------------------------------------------
// Digital input toggle channels package
// Command, mode and register codes and the per-channel update functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ditc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_BIT_SET  = 2'd1,
    CMD_PERIODIC = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_DIRECT  = 2'd0,
    MODE_BTOGGLE = 2'd1,
    MODE_STOGGLE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_INVERT     = 3'd1,
    REG_MODE       = 3'd2,
    REG_TARGETS_LO = 3'd3,
    REG_TARGETS_HI = 3'd4
  } cfg_reg_t;

  localparam int BIT_LEVEL   = 0;
  localparam int BIT_BUS     = 1;
  localparam int BIT_RELEASE = 2;

  localparam logic [3:0] BUS_LENGTH = 4'd2;

  typedef struct packed {
    logic accept;
    logic emit;
  } ditc_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic hit;
    logic pend_none;
    logic out_free;
  } ditc_sts_t;

  typedef struct packed {
    logic       send;
    logic       bit_val;
    logic [7:0] st;
  } samp_res_t;

  function automatic samp_res_t chan_sample(logic [7:0] st, logic lvl, mode_t mode);
    samp_res_t  r;
    logic [7:0] s;
    s         = st;
    r.send    = 1'b0;
    r.bit_val = 1'b0;
    unique case (mode)
      MODE_DIRECT: begin
        r.send    = 1'b1;
        r.bit_val = lvl;
        s         = {7'd0, lvl};
      end
      MODE_BTOGGLE: begin
        if (!s[BIT_RELEASE] && lvl) begin
          s[BIT_BUS]     = ~s[BIT_BUS];
          r.bit_val      = s[BIT_BUS];
          r.send         = 1'b1;
          s[BIT_RELEASE] = 1'b1;
        end else if (s[BIT_RELEASE] && !lvl) begin
          s[BIT_RELEASE] = 1'b0;
        end
        s[BIT_LEVEL] = lvl;
      end
      MODE_STOGGLE: begin
        s[BIT_BUS]   = ~s[BIT_BUS];
        r.bit_val    = s[BIT_BUS];
        r.send       = 1'b1;
        s[BIT_LEVEL] = lvl;
      end
      MODE_NONE: begin
        s = st;
      end
    endcase
    r.st = s;
    return r;
  endfunction

  function automatic logic [7:0] chan_bus(logic [7:0] st, cmd_t cmd, logic [7:0] value,
                                          mode_t mode);
    logic [7:0] s;
    logic       set;
    s   = st;
    set = (cmd == CMD_BIT_SET) ? value[0] : (|value);
    unique case (mode)
      MODE_DIRECT:  s = value;
      MODE_BTOGGLE: s[BIT_BUS] = set;
      MODE_STOGGLE: s[BIT_BUS] = set;
      MODE_NONE:    s = st;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ditc_dp.sv
// ----------------------------------------------------------------------------
// Digital input toggle channels datapath
// Configuration registers, channel state, pending message mask and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ditc_dp
  import ditc_pkg::*;
#(
  parameter  int CHANNELS = 8,
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire logic [1:0]        in_command,
  input  wire logic [7:0]        in_pin_levels,
  input  wire logic [15:0]       in_packet_target,
  input  wire logic [7:0]        in_packet_value,
  input  wire logic              in_packet_multicast,
  input  wire logic [3:0]        in_packet_length,
  input  wire ditc_cmd_t         cmd,
  input  wire logic [IDX_W-1:0]  idx,
  output ditc_sts_t              sts,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [15:0]            out_msg_target,
  output logic                   out_msg_value,
  output logic                   out_last
);

  logic [CHANNELS-1:0]   en_r, inv_r;
  logic [2*CHANNELS-1:0] mode_r;
  logic [63:0]           tlo_r, thi_r;
  logic [7:0]            st_r   [CHANNELS];
  logic [7:0]            st_nxt [CHANNELS];
  logic [CHANNELS-1:0]   pend_r, pend_nxt;
  logic [CHANNELS-1:0]   sbit_r, sbit_nxt;
  logic [15:0]           tgt    [CHANNELS];
  logic [CHANNELS-1:0]   rest;
  logic                  bus_ok;
  logic                  out_valid_r, out_value_r, out_last_r;
  logic [15:0]           out_target_r;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_tgt
    if (g < 4) begin : g_lo
      assign tgt[g] = tlo_r[16*g +: 16];
    end else begin : g_hi
      assign tgt[g] = thi_r[16*(g-4) +: 16];
    end
  end

  assign bus_ok = ((cmd_t'(in_command) == CMD_BIT_SET) || (cmd_t'(in_command) == CMD_PERIODIC))
                  && in_packet_multicast && (in_packet_length == BUS_LENGTH);

  always_comb begin
    samp_res_t sr;
    logic      lvl;
    sr       = '0;
    lvl      = 1'b0;
    pend_nxt = pend_r;
    sbit_nxt = sbit_r;
    for (int i = 0; i < CHANNELS; i++) begin
      st_nxt[i] = st_r[i];
    end
    if (cmd.emit) begin
      pend_nxt[idx] = 1'b0;
    end
    if (cmd.accept) begin
      if (cmd_t'(in_command) == CMD_SAMPLE) begin
        for (int i = 0; i < CHANNELS; i++) begin
          lvl         = in_pin_levels[i] ^ inv_r[i];
          sr          = chan_sample(st_r[i], lvl, mode_t'(mode_r[2*i +: 2]));
          pend_nxt[i] = 1'b0;
          if (en_r[i] && (st_r[i][BIT_LEVEL] != lvl)) begin
            st_nxt[i]   = sr.st;
            pend_nxt[i] = sr.send;
            sbit_nxt[i] = sr.bit_val;
          end
        end
      end else if (bus_ok) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (en_r[i] && (tgt[i] == in_packet_target)) begin
            st_nxt[i] = chan_bus(st_r[i], cmd_t'(in_command), in_packet_value,
                                 mode_t'(mode_r[2*i +: 2]));
          end
        end
      end
    end
  end

  always_comb begin
    rest      = pend_r;
    rest[idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= '0;
      inv_r  <= '0;
      mode_r <= '0;
      tlo_r  <= '0;
      thi_r  <= '0;
      pend_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= st_nxt[i];
      end
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ENABLE:     en_r   <= cfg_data[CHANNELS-1:0];
          REG_INVERT:     inv_r  <= cfg_data[CHANNELS-1:0];
          REG_MODE:       mode_r <= cfg_data[2*CHANNELS-1:0];
          REG_TARGETS_LO: tlo_r  <= cfg_data;
          REG_TARGETS_HI: thi_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sbit_r <= sbit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_target_r <= tgt[idx];
      out_value_r  <= sbit_r[idx];
      out_last_r   <= ~|rest;
    end
  end

  assign sts.is_sample = (cmd_t'(in_command) == CMD_SAMPLE);
  assign sts.hit       = pend_r[idx];
  assign sts.pend_none = ~|pend_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_msg_target = out_target_r;
  assign out_msg_value  = out_value_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// File: rtl/ditc_ctrl.sv
// ----------------------------------------------------------------------------
// Digital input toggle channels controller
// Accepts items and steps the channel scan that emits at most one message per cycle while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ditc_ctrl
  import ditc_pkg::*;
#(
  parameter  int CHANNELS = 8,
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ditc_sts_t        sts,
  output ditc_cmd_t             cmd,
  output logic [IDX_W-1:0]      idx
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_sample) begin
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
          end
        end
      end
      ST_SCAN: begin
        if (sts.pend_none) begin
          state_nxt = ST_IDLE;
        end else if (!sts.hit || sts.out_free) begin
          cmd.emit = sts.hit;
          if (idx_r == IDX_W'(CHANNELS - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign idx      = idx_r;

endmodule

`default_nettype wire

// File: rtl/digital_input_toggle_channels_top.sv
// ----------------------------------------------------------------------------
// Digital input toggle channels top level
// Bank of digital input channels that reports level changes as bus messages.
// ----------------------------------------------------------------------------
// The input channel takes one item per transfer: a pin sample or a bus packet.
// A pin sample updates every enabled channel at once and then scans the
// channels in rising order, one channel per cycle unless the output stalls,
// loading one message per sending channel into the output register; the last
// message of a sample has tlast set. The scan ends early when no pending
// message is left. A bus packet does not start a scan and never produces a
// message. The next item is taken as soon as the scan is over, even while the
// last message still waits in the output register. When the receiver stalls,
// the scan waits on the next sending channel and the message held at the
// output stays stable. Configuration writes are always ready and are meant to
// be done while the block is idle. Synchronous reset clears the configuration,
// the channel state and the output valid flag; the output data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module digital_input_toggle_channels_top
  import ditc_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] pin_levels, [23:8] packet_target, [31:24] packet_value,
  // [32] packet_multicast, [36:33] packet_length, [39:37] zero
  input  wire logic [39:0] in_tdata,
  // [1:0] command
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] msg_target, [16] msg_value, [23:17] zero
  output logic [23:0]      out_tdata,
  output logic             out_tlast
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ditc_cmd_t        cmd;
  ditc_sts_t        sts;
  logic [IDX_W-1:0] idx;
  logic [15:0]      msg_target;
  logic             msg_value;

  assign cfg_ready = 1'b1;

  ditc_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  ditc_dp #(
    .CHANNELS(CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_command          (in_tuser),
    .in_pin_levels       (in_tdata[7:0]),
    .in_packet_target    (in_tdata[23:8]),
    .in_packet_value     (in_tdata[31:24]),
    .in_packet_multicast (in_tdata[32]),
    .in_packet_length    (in_tdata[36:33]),
    .cmd                 (cmd),
    .idx                 (idx),
    .sts                 (sts),
    .out_ready           (out_tready),
    .out_valid           (out_tvalid),
    .out_msg_target      (msg_target),
    .out_msg_value       (msg_value),
    .out_last            (out_tlast)
  );

  assign out_tdata = {7'd0, msg_value, msg_target};

endmodule

`default_nettype wire

// File: rtl/ditc_chk.sv
// ----------------------------------------------------------------------------
// Digital input toggle channels port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digital_input_toggle_channels_top_macros.svh"

module ditc_chk
  import ditc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  `DITC_ASSERT_RESET(a_reset_clears, !out_tvalid && in_tready, "reset left output or input busy")

  `DITC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output transfer changed")

  `DITC_ASSERT_NEXT(a_bus_one_cycle, in_tvalid && in_tready && (in_tuser != CMD_SAMPLE), in_tready, "bus item did not finish in one cycle")

  `DITC_ASSERT_NEXT(a_sample_scans, in_tvalid && in_tready && (in_tuser == CMD_SAMPLE), !in_tready, "sample transfer did not start a scan")

endmodule

bind digital_input_toggle_channels_top ditc_chk u_chk (.*);

`default_nettype wire
